/* sv/fsrs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsrs_pkg: shared definitions of the fair-share request scheduler
//
// Holds the transaction payload types, operation and status codes, the
// default sizing and the command and status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package fsrs_pkg;

    // Field widths fixed by the request and response formats.
    localparam int FUNC_W   = 3;
    localparam int CLIENT_W = 4;
    localparam int SVC_W    = 48;
    localparam int STATUS_W = 2;

    // Default sizing of the client table.
    localparam int CLIENTS_DEF     = 16;
    localparam int MAX_RUNNING_DEF = 255;

    // Service time saturates at the largest value its field can hold.
    localparam logic [SVC_W-1:0] SVC_MAX = {SVC_W{1'b1}};

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_CREATE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PICK    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DONE    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ENABLE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DISABLE = 3'd4;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CLIENT_W-1:0] client;
        logic [SVC_W-1:0]    now_us;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLIENT_W-1:0] granted;
        logic [SVC_W-1:0]    granted_service;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the accepted request
        logic cnt_clear;     // restart the client sweep counter
        logic best_clear;    // forget the current pick candidate
        logic issue_scan;    // read the next client for comparison
        logic issue_commit;  // read the next client for write-back
        logic issue_single;  // read the addressed client
        logic decide;        // settle the pick result
        logic res_fail;      // result is a failed check
        logic out_load;      // move the result to the response register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_pick;       // captured request is a pick
        logic op_single;     // captured request is a valid per-client operation
        logic cnt_last;      // sweep counter is on the last client
        logic pipe_busy;     // reads still travelling through the pipeline
        logic best_found;    // an enabled client was seen in the sweep
        logic best_full;     // candidate already has the maximum running count
    } stat_t;

endpackage
`default_nettype wire

/* sv/fair_share_request_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fair_share_request_scheduler: least-service fair-share scheduler
//
// Top level joining the sequencing controller and the client-table
// datapath.
// ----------------------------------------------------------------------------
// The scheduler keeps a table of CLIENTS client slots, each with an
// accumulated service time, a count of running requests, the time of its
// last update and an enabled flag. A pick brings every client's service
// time up to now_us (elapsed time multiplied by the running count, saturated
// at the 48-bit maximum), grants the enabled client with the least service
// time, lowest index on ties, raises its running count and records its
// service time as the floor. Done, enable, disable and create act on one
// client, and any failed check answers status 2 with the table unchanged.
// Requests are taken one at a time. The client table sits in a memory
// with one read port, so a comparison sweep and a write-back sweep each
// visit one client per cycle, and each sweep drains through a multiply
// stage and a saturate-and-compare stage. A new request is accepted while
// the previous response still waits to be taken; the response register
// holds it.
// ----------------------------------------------------------------------------
module fair_share_request_scheduler
#(
    parameter int CLIENTS     = fsrs_pkg::CLIENTS_DEF,
    parameter int MAX_RUNNING = fsrs_pkg::MAX_RUNNING_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire fsrs_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output fsrs_pkg::rsp_t      rsp
);

    // Command and status bundles between the controller and the datapath.
    fsrs_pkg::cmd_t  cmd;
    fsrs_pkg::stat_t stat;

    // The controller owns the handshakes and the response valid flag.
    fsrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // The datapath holds the client table, the update pipeline and the
    // response payload.
    fsrs_datapath
    #(
        .CLIENTS     (CLIENTS),
        .MAX_RUNNING (MAX_RUNNING)
    )
    u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
`default_nettype wire

/* sv/fsrs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsrs_ctrl: sequencing controller of the fair-share request scheduler
//
// Accepts one request at a time, steps the datapath through its sweeps or
// its single-client update and hands the result to the response register.
// ----------------------------------------------------------------------------
module fsrs_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output fsrs_pkg::cmd_t     cmd,
    input  wire fsrs_pkg::stat_t stat
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_SCAN     = 8'b0000_0100,
        S_SDRAIN   = 8'b0000_1000,
        S_DECIDE   = 8'b0001_0000,
        S_COMMIT   = 8'b0010_0000,
        S_DRAIN    = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op_pick)
                begin
                    cmd.cnt_clear  = 1'b1;
                    cmd.best_clear = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (stat.op_single)
                begin
                    cmd.issue_single = 1'b1;
                    state_next       = S_DRAIN;
                end
                else
                begin
                    cmd.res_fail = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.issue_scan = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_SDRAIN;
                end
            end
            S_SDRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide    = 1'b1;
                cmd.cnt_clear = 1'b1;
                // A winner that cannot take another request leaves the client table and the floor alone.
                if (stat.best_found && stat.best_full)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.issue_commit = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule
`default_nettype wire

/* sv/fsrs_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsrs_datapath: client table and update pipeline of the scheduler
//
// Keeps the client table in a single-port-read memory, runs each read
// through a multiply stage and a saturate-and-compare stage, tracks the
// pick candidate and holds the result and response registers.
// ----------------------------------------------------------------------------
module fsrs_datapath
#(
    parameter int CLIENTS     = fsrs_pkg::CLIENTS_DEF,
    parameter int MAX_RUNNING = fsrs_pkg::MAX_RUNNING_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fsrs_pkg::req_t   req,
    output fsrs_pkg::rsp_t        rsp,
    input  wire fsrs_pkg::cmd_t   cmd,
    output fsrs_pkg::stat_t       stat
);

    localparam int IW = $clog2(CLIENTS);
    localparam int RW = $clog2(MAX_RUNNING + 1);
    localparam int SW = fsrs_pkg::SVC_W;
    localparam int PW = SW + RW;
    localparam logic [IW-1:0] LAST_IDX = IW'(CLIENTS - 1);
    localparam logic [RW-1:0] RUN_MAX  = RW'(MAX_RUNNING);

    typedef struct packed {
        logic [SW-1:0] svc;
        logic [RW-1:0] run;
        logic [SW-1:0] last;
    } entry_t;

    typedef enum logic [1:0] {
        PASS_SCAN,
        PASS_COMMIT,
        PASS_SINGLE
    } pass_t;

    // Captured request.
    fsrs_pkg::req_t req_reg;

    // Client table.
    entry_t             mem [CLIENTS];
    logic [CLIENTS-1:0] valid_reg;
    logic [CLIENTS-1:0] en_reg;

    logic [IW-1:0] cnt_reg;

    // Read stage.
    logic          s1_vld_reg;
    pass_t         s1_mode_reg;
    logic [IW-1:0] s1_idx_reg;
    entry_t        s1_ent_reg;
    logic          s1_ok_reg;
    logic          s1_en_reg;

    // Product stage.
    logic          s2_vld_reg;
    pass_t         s2_mode_reg;
    logic [IW-1:0] s2_idx_reg;
    logic [PW-1:0] s2_prod_reg;
    logic [SW-1:0] s2_svc_reg;
    logic [RW-1:0] s2_run_reg;
    logic [SW-1:0] s2_last_reg;
    logic          s2_en_reg;

    // Pick candidate and floor.
    logic          best_found_reg;
    logic [IW-1:0] best_idx_reg;
    logic [SW-1:0] best_svc_reg;
    logic [RW-1:0] best_run_reg;
    logic [SW-1:0] floor_reg;

    fsrs_pkg::rsp_t res_reg;
    fsrs_pkg::rsp_t out_reg;

    // Read issue.
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    pass_t         rd_mode;

    // Stage one arithmetic.
    entry_t        s1_ent;
    logic [SW-1:0] s1_elapsed;
    logic [PW-1:0] s1_prod;

    // Stage two arithmetic and actions.
    logic [SW:0]   grow_sum;
    logic [SW-1:0] upd_svc;
    logic [SW:0]   floor_sum;
    logic [SW-1:0] floor_add;
    logic          wr_en;
    entry_t        wr_data;
    logic          en_set;
    logic          en_clr;
    logic          best_take;
    logic          res_wr;
    logic [fsrs_pkg::STATUS_W-1:0] res_status;
    logic          in_range;

    assign in_range = (32'(req_reg.client) < CLIENTS);

    assign rd_en   = cmd.issue_scan | cmd.issue_commit | cmd.issue_single;
    assign rd_addr = cmd.issue_single ? IW'(req_reg.client) : cnt_reg;

    always_comb
    begin
        if (cmd.issue_single)
        begin
            rd_mode = PASS_SINGLE;
        end
        else if (cmd.issue_commit)
        begin
            rd_mode = PASS_COMMIT;
        end
        else
        begin
            rd_mode = PASS_SCAN;
        end
    end

    // Elapsed time times the running count; a never-written entry reads as zero.
    always_comb
    begin
        s1_ent     = s1_ok_reg ? s1_ent_reg : '0;
        s1_elapsed = (req_reg.now_us > s1_ent.last) ? (req_reg.now_us - s1_ent.last) : '0;
        s1_prod    = {{RW{1'b0}}, s1_elapsed} * {{SW{1'b0}}, s1_ent.run};
    end

    // Saturating service update and floor addition.
    always_comb
    begin
        grow_sum  = {1'b0, s2_svc_reg} + {1'b0, s2_prod_reg[SW-1:0]};
        upd_svc   = ((|s2_prod_reg[PW-1:SW]) || grow_sum[SW]) ? fsrs_pkg::SVC_MAX
                                                              : grow_sum[SW-1:0];
        floor_sum = {1'b0, s2_svc_reg} + {1'b0, floor_reg};
        floor_add = floor_sum[SW] ? fsrs_pkg::SVC_MAX : floor_sum[SW-1:0];
    end

    always_comb
    begin
        wr_en      = 1'b0;
        wr_data    = '0;
        en_set     = 1'b0;
        en_clr     = 1'b0;
        best_take  = 1'b0;
        res_wr     = 1'b0;
        res_status = fsrs_pkg::ST_FAIL;
        if (s2_vld_reg)
        begin
            case (s2_mode_reg)
                PASS_SCAN:
                begin
                    best_take = s2_en_reg && (!best_found_reg || (upd_svc < best_svc_reg));
                end
                PASS_COMMIT:
                begin
                    wr_en        = 1'b1;
                    wr_data.svc  = upd_svc;
                    wr_data.last = req_reg.now_us;
                    if (best_found_reg && (s2_idx_reg == best_idx_reg))
                    begin
                        wr_data.run = s2_run_reg + RW'(1);
                    end
                    else
                    begin
                        wr_data.run = s2_run_reg;
                    end
                end
                PASS_SINGLE:
                begin
                    res_wr = 1'b1;
                    case (req_reg.func)
                        fsrs_pkg::FUNC_CREATE:
                        begin
                            wr_en        = 1'b1;
                            wr_data.last = req_reg.now_us;
                            en_clr       = 1'b1;
                            res_status   = fsrs_pkg::ST_OK;
                        end
                        fsrs_pkg::FUNC_DONE:
                        begin
                            if (s2_run_reg != '0)
                            begin
                                wr_en        = 1'b1;
                                wr_data.svc  = upd_svc;
                                wr_data.run  = s2_run_reg - RW'(1);
                                wr_data.last = req_reg.now_us;
                                res_status   = fsrs_pkg::ST_OK;
                            end
                        end
                        fsrs_pkg::FUNC_ENABLE:
                        begin
                            if (!s2_en_reg)
                            begin
                                wr_en        = 1'b1;
                                wr_data.svc  = floor_add;
                                wr_data.run  = s2_run_reg;
                                wr_data.last = s2_last_reg;
                                en_set       = 1'b1;
                                res_status   = fsrs_pkg::ST_OK;
                            end
                        end
                        fsrs_pkg::FUNC_DISABLE:
                        begin
                            if (s2_en_reg && (s2_svc_reg >= floor_reg))
                            begin
                                wr_en        = 1'b1;
                                wr_data.svc  = s2_svc_reg - floor_reg;
                                wr_data.run  = s2_run_reg;
                                wr_data.last = s2_last_reg;
                                en_clr       = 1'b1;
                                res_status   = fsrs_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            res_status = fsrs_pkg::ST_FAIL;
                        end
                    endcase
                end
                default:
                begin
                    best_take = 1'b0;
                end
            endcase
        end
    end

    // Client table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s2_idx_reg] <= wr_data;
        end
        if (rd_en)
        begin
            s1_ent_reg <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            en_reg         <= '0;
            cnt_reg        <= '0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[s2_idx_reg] <= 1'b1;
            end
            if (en_set)
            begin
                en_reg[s2_idx_reg] <= 1'b1;
            end
            else if (en_clr)
            begin
                en_reg[s2_idx_reg] <= 1'b0;
            end
            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.issue_scan || cmd.issue_commit)
            begin
                cnt_reg <= cnt_reg + IW'(1);
            end
            s1_vld_reg <= rd_en;
            s2_vld_reg <= s1_vld_reg;
            if (cmd.best_clear)
            begin
                best_found_reg <= 1'b0;
            end
            else if (best_take)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        s1_mode_reg <= rd_mode;
        s1_idx_reg  <= rd_addr;
        s1_ok_reg   <= valid_reg[rd_addr];
        s1_en_reg   <= en_reg[rd_addr];
        s2_mode_reg <= s1_mode_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_prod_reg <= s1_prod;
        s2_svc_reg  <= s1_ent.svc;
        s2_run_reg  <= s1_ent.run;
        s2_last_reg <= s1_ent.last;
        s2_en_reg   <= s1_en_reg;
        if (best_take)
        begin
            best_idx_reg <= s2_idx_reg;
            best_svc_reg <= upd_svc;
            best_run_reg <= s2_run_reg;
        end
        if (cmd.decide)
        begin
            res_reg <= '0;
            if (!best_found_reg)
            begin
                res_reg.status <= fsrs_pkg::ST_NONE;
            end
            else if (best_run_reg >= RUN_MAX)
            begin
                res_reg.status <= fsrs_pkg::ST_FAIL;
            end
            else
            begin
                res_reg.status          <= fsrs_pkg::ST_OK;
                res_reg.granted         <= fsrs_pkg::CLIENT_W'(best_idx_reg);
                res_reg.granted_service <= best_svc_reg;
            end
        end
        else if (cmd.res_fail)
        begin
            res_reg        <= '0;
            res_reg.status <= fsrs_pkg::ST_FAIL;
        end
        else if (res_wr)
        begin
            res_reg        <= '0;
            res_reg.status <= res_status;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // The floor starts at zero and follows the winner of each granted pick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
        end
        else if (cmd.decide && best_found_reg && (best_run_reg < RUN_MAX))
        begin
            floor_reg <= best_svc_reg;
        end
    end

    always_comb
    begin
        stat.op_pick    = (req_reg.func == fsrs_pkg::FUNC_PICK);
        stat.op_single  = in_range && (req_reg.func inside {fsrs_pkg::FUNC_CREATE,
                                                           fsrs_pkg::FUNC_DONE,
                                                           fsrs_pkg::FUNC_ENABLE,
                                                           fsrs_pkg::FUNC_DISABLE});
        stat.cnt_last   = (cnt_reg == LAST_IDX);
        stat.pipe_busy  = s1_vld_reg | s2_vld_reg;
        stat.best_found = best_found_reg;
        stat.best_full  = (best_run_reg >= RUN_MAX);
    end

    assign rsp = out_reg;

endmodule
`default_nettype wire
